// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the blend core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

// ----- hdl/pua_pkg.sv -----
// Shared types and constants for the pixel unpack and alpha blend core.
package pua_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_BLEND_OP          = 3'd0;
  localparam logic [2:0] REG_DEST_FORMAT       = 3'd1;
  localparam logic [2:0] REG_DEST_RGB_ORDER    = 3'd2;
  localparam logic [2:0] REG_DEST_NO_ALPHA     = 3'd3;
  localparam logic [2:0] REG_DEST_SHIFT_CONVERT = 3'd4;

  // Blend operation codes with special meaning
  localparam logic [6:0] BLEND_OP_PASS_A    = 7'd8;
  localparam logic [6:0] BLEND_OP_PASS_B    = 7'd16;
  localparam logic [6:0] BLEND_OP_PREMULT_A = 7'd40;
  localparam logic [6:0] BLEND_OP_PREMULT_B = 7'd81;

  typedef struct packed {
    logic [6:0] blend_op;
    logic [4:0] dest_format;
    logic       dest_rgb_order;
    logic       dest_no_alpha;
    logic       dest_shift_convert;
  } cfg_t;

  typedef enum logic [1:0] {
    MODE_ALPHA,
    MODE_PREMULT,
    MODE_PASS
  } blend_mode_t;

endpackage

// ----- hdl/pua_cfg_regs.sv -----
// Configuration register file for the blend core.
module pua_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [6:0]        cfg_data,
  output pua_pkg::cfg_t     cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pua_pkg::REG_BLEND_OP:           cfg.blend_op           <= cfg_data;
        pua_pkg::REG_DEST_FORMAT:        cfg.dest_format        <= cfg_data[4:0];
        pua_pkg::REG_DEST_RGB_ORDER:     cfg.dest_rgb_order     <= cfg_data[0];
        pua_pkg::REG_DEST_NO_ALPHA:      cfg.dest_no_alpha      <= cfg_data[0];
        pua_pkg::REG_DEST_SHIFT_CONVERT: cfg.dest_shift_convert <= cfg_data[0];
        default: begin
          // drop writes outside the register list
        end
      endcase
    end
  end

endmodule

// ----- hdl/pua_unpack.sv -----
// Destination pixel unpack to four 8-bit components.
module pua_unpack (
  input  pua_pkg::cfg_t cfg,
  input  logic [31:0]   raw_pixel,
  output logic [31:0]   dest_unpacked
);

  localparam logic [4:0] FMT_8888      = 5'd0;
  localparam logic [4:0] FMT_5551      = 5'd1;
  localparam logic [4:0] FMT_4444      = 5'd2;
  localparam logic [4:0] FMT_332       = 5'd5;
  localparam logic [4:0] FMT_332_HI    = 5'd6;
  localparam logic [4:0] FMT_2321      = 5'd9;
  localparam logic [4:0] FMT_2321_HI   = 5'd10;
  localparam logic [4:0] FMT_232_OFS   = 5'd11;
  localparam logic [4:0] FMT_232_OFS_HI = 5'd12;
  localparam logic [4:0] FMT_5551_HI   = 5'd13;
  localparam logic [4:0] FMT_GREY8     = 5'd14;
  localparam logic [4:0] FMT_GREY4     = 5'd15;
  localparam logic [4:0] FMT_565       = 5'd16;
  localparam logic [4:0] FMT_565_HI    = 5'd17;

  localparam logic [6:0] OFFSET_332 = 7'd64;

  typedef enum logic [1:0] {
    KIND_FIELDS,
    KIND_GREY8,
    KIND_GREY4,
    KIND_RAW
  } kind_t;

  // Take a field and widen it to 8 bits, by replication or zero fill.
  function automatic logic [7:0] widen(logic [31:0] v, logic [3:0] width,
                                       logic [4:0] pos, logic zero_fill);
    logic [31:0] shifted;
    logic [7:0]  field;
    logic [7:0]  aligned;
    logic [7:0]  o;
    int          i;
    shifted = v >> pos;
    field   = shifted[7:0] & 8'((9'd1 << width) - 9'd1);
    aligned = field << (4'd8 - width);
    o       = aligned;
    if (!zero_fill) begin
      for (i = 1; i < 8; i++) begin
        if (i * int'(width) < 8) begin
          o = o | (aligned >> (i * int'(width)));
        end
      end
    end
    return o;
  endfunction

  logic [3:0]  rw, gw, bw, aw;
  logic [4:0]  up;
  logic        off;
  kind_t       kind;
  logic [31:0] v;
  logic [6:0]  v_ofs;
  logic [7:0]  r, g, b, a;
  logic [4:0]  r_pos, g_pos, b_pos, a_pos;
  logic [7:0]  grey;

  always_comb begin
    rw = 4'd0; gw = 4'd0; bw = 4'd0; aw = 4'd0;
    up = 5'd0; off = 1'b0; kind = KIND_FIELDS;
    case (cfg.dest_format)
      FMT_8888:       begin rw = 4'd8; gw = 4'd8; bw = 4'd8; aw = 4'd8; end
      FMT_5551:       begin rw = 4'd5; gw = 4'd5; bw = 4'd5; aw = 4'd1; end
      FMT_5551_HI:    begin rw = 4'd5; gw = 4'd5; bw = 4'd5; aw = 4'd1; up = 5'd16; end
      FMT_4444:       begin rw = 4'd4; gw = 4'd4; bw = 4'd4; aw = 4'd4; end
      FMT_332:        begin rw = 4'd3; gw = 4'd3; bw = 4'd2; end
      FMT_332_HI:     begin rw = 4'd3; gw = 4'd3; bw = 4'd2; up = 5'd8; end
      FMT_2321:       begin rw = 4'd2; gw = 4'd3; bw = 4'd2; aw = 4'd1; end
      FMT_2321_HI:    begin rw = 4'd2; gw = 4'd3; bw = 4'd2; aw = 4'd1; up = 5'd8; end
      FMT_232_OFS:    begin rw = 4'd2; gw = 4'd3; bw = 4'd2; off = 1'b1; end
      FMT_232_OFS_HI: begin rw = 4'd2; gw = 4'd3; bw = 4'd2; up = 5'd8; off = 1'b1; end
      FMT_565:        begin rw = 4'd5; gw = 4'd6; bw = 4'd5; end
      FMT_565_HI:     begin rw = 4'd5; gw = 4'd6; bw = 4'd5; up = 5'd16; end
      FMT_GREY8:      kind = KIND_GREY8;
      FMT_GREY4:      kind = KIND_GREY4;
      default:        kind = KIND_RAW;
    endcase

    v     = raw_pixel >> up;
    v_ofs = v[6:0] - OFFSET_332;
    if (off) begin
      v = {25'd0, v_ofs};
    end

    if (cfg.dest_rgb_order) begin
      b_pos = 5'd0;
      g_pos = {1'b0, bw};
      r_pos = 5'({1'b0, bw} + {1'b0, gw});
    end else begin
      r_pos = 5'd0;
      g_pos = {1'b0, rw};
      b_pos = 5'({1'b0, rw} + {1'b0, gw});
    end
    a_pos = 5'({1'b0, rw} + {1'b0, gw} + {1'b0, bw});

    r = widen(v, rw, r_pos, cfg.dest_shift_convert);
    g = widen(v, gw, g_pos, cfg.dest_shift_convert);
    b = widen(v, bw, b_pos, cfg.dest_shift_convert);
    if (cfg.dest_no_alpha || aw == 4'd0) begin
      a = 8'hff;
    end else begin
      a = widen(v, aw, a_pos, cfg.dest_shift_convert);
    end

    // 4-bit grey index times 17 is the nibble repeated
    grey = (kind == KIND_GREY4) ? {raw_pixel[3:0], raw_pixel[3:0]} : raw_pixel[7:0];

    case (kind)
      KIND_FIELDS:            dest_unpacked = {a, b, g, r};
      KIND_GREY8, KIND_GREY4: dest_unpacked = {8'hff, grey, grey, grey};
      default:                dest_unpacked = raw_pixel;
    endcase
  end

endmodule

// ----- hdl/pua_weight.sv -----
// Per-channel weighting products for the blend.
module pua_weight (
  input  pua_pkg::blend_mode_t mode,
  input  logic [31:0]          src,
  input  logic [31:0]          dst,
  output logic [3:0][15:0]     num,
  output logic [3:0][7:0]      addend
);

  logic [7:0] as;
  logic [7:0] inv_as;

  assign as     = src[31:24];
  assign inv_as = 8'hff - as;

  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      if (mode == pua_pkg::MODE_PREMULT) begin
        num[ch]    = 16'(dst[ch*8 +: 8]) * 16'(inv_as);
        addend[ch] = src[ch*8 +: 8];
      end else begin
        num[ch]    = 16'(16'(src[ch*8 +: 8]) * 16'(as) + 16'(dst[ch*8 +: 8]) * 16'(inv_as));
        addend[ch] = 8'd0;
      end
    end
  end

endmodule

// ----- hdl/pua_scale.sv -----
// Divide by 255, add the premultiplied term and saturate each channel; in pass mode the source goes through unchanged.
module pua_scale (
  input  pua_pkg::blend_mode_t mode,
  input  logic [31:0]          src,
  input  logic [3:0][15:0]     num,
  input  logic [3:0][7:0]      addend,
  output logic [31:0]          result
);

  logic [3:0][16:0] t;
  logic [3:0][9:0]  sum;

  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      // x / 255 == (x + (x >> 8) + 1) >> 8 across the 16-bit range used here
      t[ch]   = 17'(num[ch]) + 17'(num[ch] >> 8) + 17'd1;
      sum[ch] = 10'(t[ch][16:8]) + 10'(addend[ch]);
      result[ch*8 +: 8] = (sum[ch] > 10'd255) ? 8'hff : sum[ch][7:0];
    end
    if (mode == pua_pkg::MODE_PASS) begin
      result = src;
    end
  end

endmodule

// ----- hdl/pixel_unpack_alpha_blend_core.sv -----
// Top level of the pixel unpack and alpha blend core.
// Takes one source colour and one raw destination pixel per transaction and
// returns one blended colour, red in bits 7..0 through alpha in bits 31..24.
// Throughput is one transaction per clock while the output is not stalled;
// an accepted input reaches the output through the two register stages, the
// input register and output register, with the unpack, the per-channel 8x8
// multipliers, the divide by 255 and the saturation all between them. The
// core holds at most two transactions: while a finished result waits on the
// output it still accepts one more into the input register, then in_ready
// drops until the output is taken (in_ready follows out_ready in the same
// cycle). No state is kept between pixels and there is no clearing pass
// after reset. Configuration writes are always taken (cfg_ready is tied
// high); change registers only while no transaction is in flight, since the
// live register values steer the datapath.
`include "assert_macros.svh"

module pixel_unpack_alpha_blend_core (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] source_color,
  input  logic [31:0] dest_pixel,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] blended_color
);

  pua_pkg::cfg_t cfg;

  pua_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage occupancy and flow: a stage opens when empty or when it drains
  logic a_valid;
  logic a_open, c_open;

  assign c_open   = !out_valid || out_ready;
  assign a_open   = !a_valid || c_open;
  assign in_ready = a_open;

  // Input register
  logic [31:0] a_src, a_dst;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_open) begin
      a_valid <= in_valid;
    end
    if (a_open && in_valid) begin
      a_src <= source_color;
      a_dst <= dest_pixel;
    end
  end

  // Decode the blend rule from the operation code
  pua_pkg::blend_mode_t mode;

  always_comb begin
    if (cfg.blend_op == pua_pkg::BLEND_OP_PASS_A || cfg.blend_op == pua_pkg::BLEND_OP_PASS_B) begin
      mode = pua_pkg::MODE_PASS;
    end else if (cfg.blend_op == pua_pkg::BLEND_OP_PREMULT_A ||
                 cfg.blend_op == pua_pkg::BLEND_OP_PREMULT_B) begin
      mode = pua_pkg::MODE_PREMULT;
    end else begin
      mode = pua_pkg::MODE_ALPHA;
    end
  end

  // Unpack the destination and form the channel products
  logic [31:0]      dst_unpacked;
  logic [3:0][15:0] num;
  logic [3:0][7:0]  addend;

  pua_unpack u_unpack (
    .cfg           (cfg),
    .raw_pixel     (a_dst),
    .dest_unpacked (dst_unpacked)
  );

  pua_weight u_weight (
    .mode   (mode),
    .src    (a_src),
    .dst    (dst_unpacked),
    .num    (num),
    .addend (addend)
  );

  // Scale, saturate and hold the result until the transaction completes
  logic [31:0] result;
  logic        c_load;

  pua_scale u_scale (
    .mode   (mode),
    .src    (a_src),
    .num    (num),
    .addend (addend),
    .result (result)
  );

  assign c_load = c_open && a_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_open) begin
      out_valid <= a_valid;
    end
    if (c_load) begin
      blended_color <= result;
    end
  end

  // A pass-through item leaves with its source colour untouched
  `ASSERT_NEXT(a_pass_through, clk, rst,
               c_load && mode == pua_pkg::MODE_PASS,
               blended_color == $past(a_src),
               "pass-through result differs from source")
  // A stalled input stage keeps its item
  `ASSERT_NEXT(a_input_hold, clk, rst,
               a_valid && !c_open,
               a_valid && $stable(a_src) && $stable(a_dst),
               "input stage lost or changed a stalled item")
  // No result appears without an item in the input stage
  `ASSERT_NEXT(a_no_phantom, clk, rst,
               !a_valid && !out_valid,
               !out_valid,
               "result offered with no item in flight")

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the pixel unpack and alpha blend core.
`timescale 1ns / 1ps

module testbench;

  // Destination pixel formats that the unpacker knows; anything else passes raw.
  localparam logic [4:0] FMT_RGBA8888     = 5'd0;
  localparam logic [4:0] FMT_RGBA5551     = 5'd1;
  localparam logic [4:0] FMT_RGBA4444     = 5'd2;
  localparam logic [4:0] FMT_RGB332       = 5'd5;
  localparam logic [4:0] FMT_RGB332_HI    = 5'd6;
  localparam logic [4:0] FMT_RGBA2321     = 5'd9;
  localparam logic [4:0] FMT_RGBA2321_HI  = 5'd10;
  localparam logic [4:0] FMT_RGB232_OFF   = 5'd11;
  localparam logic [4:0] FMT_RGB232_OFFHI = 5'd12;
  localparam logic [4:0] FMT_RGBA5551_HI  = 5'd13;
  localparam logic [4:0] FMT_GREY8        = 5'd14;
  localparam logic [4:0] FMT_GREY4        = 5'd15;
  localparam logic [4:0] FMT_RGB565       = 5'd16;
  localparam logic [4:0] FMT_RGB565_HI    = 5'd17;
  localparam logic [4:0] FMT_UNKNOWN_LO   = 5'd3;
  localparam logic [4:0] FMT_UNKNOWN_TOP  = 5'd31;

  localparam logic [6:0] BLEND_OP_ALPHA_LO  = 7'd0;
  localparam logic [6:0] BLEND_OP_ALPHA_TOP = 7'd127;

  // Two register stages from input to output.
  localparam int LATENCY       = 2;
  localparam int DRAIN_CYCLES  = 2 * LATENCY + 2;
  localparam int PHASE_ITEMS   = 350;
  localparam int SETTING_ITEMS = 35;
  localparam int LONG_STALL    = 400;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct {
    pua_pkg::cfg_t cfg;
    logic [31:0]   src;
    logic [31:0]   dst;
    logic [31:0]   want;
    bit            known;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [6:0]  cfg_data = 7'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] source_color = 32'd0;
  logic [31:0] dest_pixel = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] blended_color;

  // Register image as the core should hold it; all fields reset to zero.
  pua_pkg::cfg_t live_cfg = '0;
  logic [31:0]   blended_expected[$];
  stim_row_t     directed_rows[$];
  int            error_count = 0;
  int            cycle_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;

  // Toggle stall_req to make the receiver hold off out_ready for one long stall.
  logic        stall_req = 1'b0;
  logic        stall_seen = 1'b0;
  int          stall_left = 0;

  pixel_unpack_alpha_blend_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .source_color (source_color),
    .dest_pixel   (dest_pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .blended_color(blended_color)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Widen one narrow field to 8 bits: zeros below, or its bits repeated down.
  function automatic logic [7:0] widen_field(logic [31:0] v, int unsigned width,
                                             int unsigned pos, bit shift_only);
    logic [31:0] o;
    o = ((v >> pos) & ((32'd1 << width) - 32'd1)) << (8 - width);
    if (!shift_only) begin
      for (int unsigned s = width; s < 8; s += width)
        o |= o >> s;
    end
    return o[7:0];
  endfunction

  // Unpack a raw destination pixel to four 8-bit components, red lowest.
  function automatic logic [31:0] expand_dest(logic [31:0] raw);
    int unsigned rw, gw, bw, aw, base;
    bit          offset;
    logic [31:0] v;
    logic [7:0]  r, g, b, a, grey;
    base   = 0;
    offset = 1'b0;
    case (live_cfg.dest_format)
      FMT_RGBA8888:     begin rw = 8; gw = 8; bw = 8; aw = 8; end
      FMT_RGBA5551:     begin rw = 5; gw = 5; bw = 5; aw = 1; end
      FMT_RGBA5551_HI:  begin rw = 5; gw = 5; bw = 5; aw = 1; base = 16; end
      FMT_RGBA4444:     begin rw = 4; gw = 4; bw = 4; aw = 4; end
      FMT_RGB332:       begin rw = 3; gw = 3; bw = 2; aw = 0; end
      FMT_RGB332_HI:    begin rw = 3; gw = 3; bw = 2; aw = 0; base = 8; end
      FMT_RGBA2321:     begin rw = 2; gw = 3; bw = 2; aw = 1; end
      FMT_RGBA2321_HI:  begin rw = 2; gw = 3; bw = 2; aw = 1; base = 8; end
      FMT_RGB232_OFF:   begin rw = 2; gw = 3; bw = 2; aw = 0; offset = 1'b1; end
      FMT_RGB232_OFFHI: begin
        rw = 2; gw = 3; bw = 2; aw = 0; base = 8; offset = 1'b1;
      end
      FMT_RGB565:       begin rw = 5; gw = 6; bw = 5; aw = 0; end
      FMT_RGB565_HI:    begin rw = 5; gw = 6; bw = 5; aw = 0; base = 16; end
      FMT_GREY8: begin
        grey = raw[7:0];
        return {8'hff, grey, grey, grey};
      end
      FMT_GREY4: begin
        grey = {raw[3:0], raw[3:0]};
        return {8'hff, grey, grey, grey};
      end
      default: return raw;
    endcase
    v = raw >> base;
    // the offset layouts take 64 off, wrapping, and keep seven bits
    if (offset)
      v = (v - 32'd64) & 32'h7f;
    if (live_cfg.dest_rgb_order) begin
      b = widen_field(v, bw, 0, live_cfg.dest_shift_convert);
      g = widen_field(v, gw, bw, live_cfg.dest_shift_convert);
      r = widen_field(v, rw, bw + gw, live_cfg.dest_shift_convert);
    end else begin
      r = widen_field(v, rw, 0, live_cfg.dest_shift_convert);
      g = widen_field(v, gw, rw, live_cfg.dest_shift_convert);
      b = widen_field(v, bw, rw + gw, live_cfg.dest_shift_convert);
    end
    if (live_cfg.dest_no_alpha || aw == 0)
      a = 8'hff;
    else
      a = widen_field(v, aw, rw + gw + bw, live_cfg.dest_shift_convert);
    return {a, b, g, r};
  endfunction

  function automatic logic [31:0] blend_pixel(logic [31:0] src, logic [31:0] dst);
    logic [31:0] d, res;
    int unsigned as, cs, cd, v;
    bit          premult;
    d = expand_dest(dst);
    if (live_cfg.blend_op == pua_pkg::BLEND_OP_PASS_A ||
        live_cfg.blend_op == pua_pkg::BLEND_OP_PASS_B)
      return src;
    as      = src[31:24];
    premult = (live_cfg.blend_op == pua_pkg::BLEND_OP_PREMULT_A ||
               live_cfg.blend_op == pua_pkg::BLEND_OP_PREMULT_B);
    res     = '0;
    for (int ch = 0; ch < 4; ch++) begin
      cs = src[8*ch +: 8];
      cd = d[8*ch +: 8];
      if (premult)
        v = cs + cd * (255 - as) / 255;
      else
        v = (cs * as + cd * (255 - as)) / 255;
      if (v > 255)
        v = 255;
      res[8*ch +: 8] = v[7:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pua_pkg::cfg_t mk_cfg(logic [6:0] op, logic [4:0] fmt, int order,
                                           int opaque, int shift_conv);
    pua_pkg::cfg_t c;
    c.blend_op           = op;
    c.dest_format        = fmt;
    c.dest_rgb_order     = 1'(order);
    c.dest_no_alpha      = 1'(opaque);
    c.dest_shift_convert = 1'(shift_conv);
    return c;
  endfunction

  function automatic stim_row_t mk_row(pua_pkg::cfg_t c, logic [31:0] src,
                                       logic [31:0] dst, logic [31:0] want, int known);
    stim_row_t row;
    row.cfg   = c;
    row.src   = src;
    row.dst   = dst;
    row.want  = want;
    row.known = 1'(known);
    return row;
  endfunction

  function automatic logic [4:0] pick_format();
    case ($urandom_range(15))
      0:  return FMT_RGBA8888;
      1:  return FMT_RGBA5551;
      2:  return FMT_RGBA5551_HI;
      3:  return FMT_RGBA4444;
      4:  return FMT_RGB332;
      5:  return FMT_RGB332_HI;
      6:  return FMT_RGBA2321;
      7:  return FMT_RGBA2321_HI;
      8:  return FMT_RGB232_OFF;
      9:  return FMT_RGB232_OFFHI;
      10: return FMT_RGB565;
      11: return FMT_RGB565_HI;
      12: return FMT_GREY8;
      13: return FMT_GREY4;
      14: return FMT_UNKNOWN_TOP;
      default: return 5'($urandom_range(31));
    endcase
  endfunction

  function automatic pua_pkg::cfg_t random_cfg();
    logic [6:0] op;
    case ($urandom_range(5))
      0: op = $urandom_range(1) ? pua_pkg::BLEND_OP_PASS_A : pua_pkg::BLEND_OP_PASS_B;
      1: op = $urandom_range(1) ? pua_pkg::BLEND_OP_PREMULT_A : pua_pkg::BLEND_OP_PREMULT_B;
      2: op = $urandom_range(1) ? BLEND_OP_ALPHA_LO : BLEND_OP_ALPHA_TOP;
      default: op = 7'($urandom_range(127));
    endcase
    return mk_cfg(op, pick_format(), int'($urandom_range(1)), int'($urandom_range(1)),
                  int'($urandom_range(1)));
  endfunction

  // Bias the source alpha towards its extremes, where the blend is easiest to get wrong.
  function automatic logic [31:0] random_source();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(3))
      0:       return {8'h00, raw[23:0]};
      1:       return {8'hff, raw[23:0]};
      default: return raw;
    endcase
  endfunction

  // Hold cfg_valid high across back-to-back writes; the caller lowers it.
  task automatic write_reg(input logic [2:0] index, input logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      pua_pkg::REG_BLEND_OP:           live_cfg.blend_op           = value;
      pua_pkg::REG_DEST_FORMAT:        live_cfg.dest_format        = value[4:0];
      pua_pkg::REG_DEST_RGB_ORDER:     live_cfg.dest_rgb_order     = value[0];
      pua_pkg::REG_DEST_NO_ALPHA:      live_cfg.dest_no_alpha      = value[0];
      pua_pkg::REG_DEST_SHIFT_CONVERT: live_cfg.dest_shift_convert = value[0];
      default: ;
    endcase
  endtask

  // Write every register; the unused upper data bits carry noise.
  task automatic apply_config(input pua_pkg::cfg_t c);
    logic [6:0] junk;
    junk = 7'($urandom);
    write_reg(pua_pkg::REG_BLEND_OP, c.blend_op);
    write_reg(pua_pkg::REG_DEST_FORMAT, {junk[6:5], c.dest_format});
    write_reg(pua_pkg::REG_DEST_RGB_ORDER, {junk[6:1], c.dest_rgb_order});
    write_reg(pua_pkg::REG_DEST_NO_ALPHA, {junk[5:0], c.dest_no_alpha});
    write_reg(pua_pkg::REG_DEST_SHIFT_CONVERT,
              {junk[4:0], junk[6], c.dest_shift_convert});
    cfg_valid <= 1'b0;
  endtask

  // Stop offering and wait until every expected colour has come back.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (blended_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leave in_valid high on return so that a following transaction can go back to back.
  task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst,
                            input logic [31:0] want, input bit known);
    in_valid     <= 1'b1;
    source_color <= src;
    dest_pixel   <= dst;
    do @(posedge clk); while (!in_ready);
    blended_expected.push_back(known ? want : blend_pixel(src, dst));
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_seen <= 1'b0;
      stall_left <= 0;
    end else if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      stall_left <= LONG_STALL;
      out_ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    logic [31:0] want;
    if (!rst && out_valid && out_ready) begin
      if (blended_expected.size() == 0) begin
        $display("%0t: blended_color with nothing expected, expected none, actual %08h",
                 $time, blended_color);
        error_count++;
      end else begin
        want = blended_expected.pop_front();
        if (blended_color !== want) begin
          $display("%0t: blended_color mismatch, expected %08h, actual %08h",
                   $time, want, blended_color);
          error_count++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[pixel_unpack_alpha_blend_core] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    pua_pkg::cfg_t last_cfg;

    // Directed rows: known colours where they follow directly from the rules.
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_RGBA8888, 0, 0, 0),
                                   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1));
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_RGBA8888, 0, 0, 0),
                                   32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 1));
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_RGBA8888, 0, 0, 0),
                                   32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 1));
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_RGBA8888, 0, 0, 0),
                                   32'hff12_3456, 32'habcd_ef01, 32'hff12_3456, 1));
    directed_rows.push_back(mk_row(mk_cfg(pua_pkg::BLEND_OP_PASS_A, FMT_RGBA8888, 0, 0, 0),
                                   32'h1234_5678, 32'hdead_beef, 32'h1234_5678, 1));
    directed_rows.push_back(mk_row(mk_cfg(pua_pkg::BLEND_OP_PASS_B, FMT_GREY4, 1, 1, 1),
                                   32'h80ff_00ff, 32'h5a5a_a5a5, 32'h80ff_00ff, 1));
    // premultiplied with transparent source saturates the three colour channels
    directed_rows.push_back(mk_row(mk_cfg(pua_pkg::BLEND_OP_PREMULT_A, FMT_RGBA8888, 0, 0, 0),
                                   32'h00ff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1));
    directed_rows.push_back(mk_row(mk_cfg(pua_pkg::BLEND_OP_PREMULT_B, FMT_RGBA8888, 0, 0, 0),
                                   32'h8080_8080, 32'h4040_4040, 32'h0, 0));
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_TOP, FMT_RGBA8888, 0, 0, 0),
                                   32'h7f10_2030, 32'h1122_3344, 32'h0, 0));
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_RGBA5551, 0, 0, 0),
                                   32'h0000_0000, 32'h0000_ffff, 32'hffff_ffff, 1));
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_RGBA5551_HI, 0, 0, 0),
                                   32'h40aa_bbcc, 32'h8000_0000, 32'h0, 0));
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_RGBA4444, 0, 0, 0),
                                   32'h0000_0000, 32'h0000_a5c3, 32'h0, 0));
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_RGB332, 0, 0, 0),
                                   32'h2000_0000, 32'hffff_ff6b, 32'h0, 0));
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_RGB332_HI, 1, 0, 0),
                                   32'h0000_0000, 32'h0000_b700, 32'h0, 0));
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_RGBA2321, 0, 0, 1),
                                   32'h0000_0000, 32'h0000_00d5, 32'h0, 0));
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_RGBA2321_HI, 1, 1, 0),
                                   32'h0000_0000, 32'h0000_ff00, 32'h0, 0));
    // offset layouts: a zero pixel wraps below zero
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_RGB232_OFF, 0, 0, 0),
                                   32'h0000_0000, 32'h0000_0000, 32'h0, 0));
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_RGB232_OFFHI, 1, 0, 1),
                                   32'h0000_0000, 32'hffff_3fff, 32'h0, 0));
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_RGB565, 1, 0, 1),
                                   32'h0000_0000, 32'h0000_f81f, 32'h0, 0));
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_RGB565_HI, 0, 1, 0),
                                   32'h3366_99cc, 32'h07e0_0000, 32'h0, 0));
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_GREY8, 0, 0, 0),
                                   32'h0000_0000, 32'h0000_00ff, 32'hffff_ffff, 1));
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_GREY4, 0, 0, 0),
                                   32'h0000_0000, 32'hffff_fff0, 32'hff00_0000, 1));
    // unknown format hands the raw pixel through
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_UNKNOWN_LO, 0, 0, 0),
                                   32'h0000_0000, 32'hcafe_f00d, 32'hcafe_f00d, 1));
    directed_rows.push_back(mk_row(mk_cfg(pua_pkg::BLEND_OP_PREMULT_B, FMT_UNKNOWN_TOP, 1, 1, 1),
                                   32'hffff_ffff, 32'h1234_5678, 32'hffff_ffff, 1));
    directed_rows.push_back(mk_row(mk_cfg(BLEND_OP_ALPHA_LO, FMT_RGBA5551, 1, 1, 1),
                                   32'h5511_2233, 32'h0000_7c1f, 32'h0, 0));

    // Hold reset before releasing it.
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part runs without idling; the first rows use the reset values.
    last_cfg = live_cfg;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg != last_cfg) begin
        drain_pipeline();
        apply_config(directed_rows[i].cfg);
        last_cfg = directed_rows[i].cfg;
      end
      send_pixel(directed_rows[i].src, directed_rows[i].dst,
                 directed_rows[i].want, directed_rows[i].known);
    end

    // Random part in three idling phases, with a new setting every SETTING_ITEMS.
    for (int phase = 0; phase < 3; phase++) begin
      drain_pipeline();
      case (phase)
        0:       begin send_idle_pct = 16; recv_idle_pct = 57; end
        1:       begin send_idle_pct = 57; recv_idle_pct = 16; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % SETTING_ITEMS == 0) begin
          drain_pipeline();
          apply_config(random_cfg());
        end
        // Hold off the receiver while the sender keeps pushing, to fill the core.
        if (phase == 2 && n == 60)
          stall_req <= ~stall_req;
        sender_gap();
        send_pixel(random_source(), $urandom, 32'h0, 1'b0);
      end
    end

    drain_pipeline();
    if (error_count == 0)
      $display("[pixel_unpack_alpha_blend_core] OK");
    else
      $display("[pixel_unpack_alpha_blend_core] ERROR");
    $finish;
  end

endmodule
